FILE: rtl/instrument_envelope_sequencer_macros.svh
// Assertion helpers used by the sequencer RTL.
`ifndef INSTRUMENT_ENVELOPE_SEQUENCER_MACROS_SVH
`define INSTRUMENT_ENVELOPE_SEQUENCER_MACROS_SVH

// Same-cycle implication, masked while reset is applied.
`define IES_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is applied.
`define IES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ies_pkg.sv
`timescale 1ns / 1ps
package ies_pkg;

  localparam int DEF_PROGRAMS = 128;
  localparam int DEF_STEPS    = 64;

  // Item kinds
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_START    = 3'd1;
  localparam logic [2:0] KIND_RELEASE  = 3'd2;
  localparam logic [2:0] KIND_STEP_WR  = 3'd3;
  localparam logic [2:0] KIND_HDR_WR   = 3'd4;

  // Header word selectors
  localparam logic [2:0] HDR_CHANNELS    = 3'd0;
  localparam logic [2:0] HDR_CLOCK       = 3'd1;
  localparam logic [2:0] HDR_LOOP_START  = 3'd2;
  localparam logic [2:0] HDR_LOOP_END    = 3'd3;
  localparam logic [2:0] HDR_REL_STOP    = 3'd4;
  localparam logic [2:0] HDR_PITCH_END   = 3'd5;
  localparam logic [2:0] HDR_PITCH_LOOP  = 3'd6;
  localparam logic [2:0] HDR_PITCH_SPEED = 3'd7;

  // Distortion codes
  localparam logic [2:0] DIST_TONE   = 3'd0;
  localparam logic [2:0] DIST_HISS   = 3'd1;
  localparam logic [2:0] DIST_BUZZY  = 3'd2;
  localparam logic [2:0] DIST_GRITTY = 3'd3;
  localparam logic [2:0] DIST_POLY5  = 3'd4;

  localparam logic [1:0] ONE_CHANNEL = 2'd1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         program_req;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [5:0]         step_index;
    logic [3:0]         volume;
    logic [2:0]         distortion;
    logic [1:0]         pitch_kind;
    logic signed [31:0] pitch_amount;
    logic [2:0]         header_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         audc;
    logic [1:0]         channel_mode;
    logic [1:0]         clock_mode;
    logic [1:0]         current_pitch_kind;
    logic signed [31:0] current_pitch_value;
    logic [6:0]         current_note;
    logic               is_silent;
  } out_item_t;

  function automatic logic [7:0] dist_bits(input logic [2:0] code);
    logic [7:0] r;
    case (code) inside
      DIST_TONE:                r = 8'ha0;
      DIST_HISS:                r = 8'h80;
      DIST_BUZZY, DIST_GRITTY:  r = 8'hc0;
      DIST_POLY5:               r = 8'h20;
      default:                  r = 8'h00;
    endcase
    return r;
  endfunction

  // floor((2*velo*vol + 127) / 254): count the thresholds 127*k - 63 that n reaches
  function automatic logic [3:0] scale_volume(input logic [6:0] velo, input logic [3:0] vol);
    logic [10:0] n;
    logic [3:0]  q;
    n = 11'(velo) * 11'(vol);
    q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (n >= 11'(127 * k - 63)) q = 4'(k);
    end
    return q;
  endfunction

endpackage

FILE: rtl/ies_ram.sv
`timescale 1ns / 1ps
module ies_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the write address returns the old word
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/instrument_envelope_sequencer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    ies_pkg::in_item_t
// out      output     out_valid / out_stall  ies_pkg::out_item_t
//
// One item per cycle sustained while the output is not stalled; each item gives
// one result, registered through accept, voice update with step table read
// and output register. The rate is set by the header memory and the two step
// memories, each read once per item with a registered read.
// Reset (rst_n low, synchronous) clears the voice to silent; the tables are
// not cleared and must be written before use.
// A stall on the output holds the whole pipeline; in_stall rises only while
// a result waits in the output register and out_stall is high.
`include "instrument_envelope_sequencer_macros.svh"
module instrument_envelope_sequencer #(
  parameter int PROGRAMS = ies_pkg::DEF_PROGRAMS,
  parameter int STEPS    = ies_pkg::DEF_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ies_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ies_pkg::out_item_t out_data
);

  localparam int PW  = PROGRAMS > 1 ? $clog2(PROGRAMS) : 1;  // program number
  localparam int IW  = $clog2(STEPS);                        // header index fields
  localparam int IXW = $clog2(STEPS + 1);                    // running indices
  localparam int SAW = $clog2(PROGRAMS * STEPS);             // step memory address

  typedef struct packed {
    logic [1:0]    channels;
    logic [1:0]    clock;
    logic [IW-1:0] loop_start;
    logic [IW-1:0] loop_end;
    logic [IW-1:0] rel_stop;
    logic [IW-1:0] pitch_end;
    logic [IW-1:0] pitch_loop;
    logic [7:0]    pitch_speed;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  // Fold the 7-bit program request onto the program count (constant table)
  function automatic logic [PW-1:0] prog_of(input logic [6:0] v);
    logic [PW-1:0] r;
    r = '0;
    for (int k = 0; k < 128; k++) begin
      if (v == 7'(k)) r = PW'(k % PROGRAMS);
    end
    return r;
  endfunction

  // Low byte of a header value, saturated to the last step
  function automatic logic [IW-1:0] sat_index(input logic [31:0] v);
    logic [7:0] b;
    b = v[7:0];
    return (9'(b) > 9'(STEPS - 1)) ? IW'(STEPS - 1) : IW'(b);
  endfunction

  function automatic logic [SAW-1:0] slot(input logic [PW-1:0] p, input logic [IXW-1:0] i);
    logic [IXW-1:0] c;
    c = (i >= IXW'(STEPS)) ? IXW'(STEPS - 1) : i;
    return SAW'(p) * SAW'(STEPS) + SAW'(c);
  endfunction

  // Pipeline control
  logic adv, in_accept, commit;

  // Stage one: accepted item, header read in flight
  logic              s1_valid_r;
  ies_pkg::in_item_t s1_item_r;
  logic [PW-1:0]     s1_prog_r;
  logic [PW-1:0]     in_prog;
  logic              hit_r;
  hdr_t              hdr_fwd_r;
  logic [HW-1:0]     hdr_q;
  hdr_t              hdr_cur, hdr_mod;
  logic              hdr_we;

  // Voice state
  logic [PW-1:0]  active_r, active_nxt;
  logic [6:0]     note_r, note_nxt;
  logic [6:0]     velo_r, velo_nxt;
  logic           rel_r, rel_nxt;
  logic           silent_r, silent_nxt;
  logic [IXW-1:0] env_r, env_nxt, env_inc;
  logic [IXW-1:0] pit_r, pit_nxt, pit_inc;
  logic [7:0]     psc_r, psc_nxt;
  hdr_t           h_r, h_nxt;

  // Step memories
  logic           step_we;
  logic [SAW-1:0] step_waddr;
  logic [6:0]     env_q;
  logic [33:0]    pitch_q;

  // Stage two: snapshot of the voice after the item
  logic       s2_valid_r;
  logic       s2_silent_r;
  logic [1:0] s2_chan_r, s2_clk_r;
  logic [6:0] s2_note_r, s2_velo_r;

  // Output register
  logic               out_valid_r;
  ies_pkg::out_item_t out_data_r, out_nxt;

  // Advance everything unless a result is stuck in the output register
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign commit    = adv && s1_valid_r;
  assign in_prog   = prog_of(in_data.program_req);

  // Header memory: read at transfer, written back when a header write commits
  ies_ram #(.WIDTH(HW), .DEPTH(PROGRAMS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (s1_prog_r),
    .wdata (hdr_mod),
    .re    (in_accept),
    .raddr (in_prog),
    .rdata (hdr_q)
  );

  // Forward a write-back that lands on the edge this item was read
  assign hdr_cur = hit_r ? hdr_fwd_r : hdr_t'(hdr_q);

  // Step tables: write straight from the transfer; the item's own reads
  // come at a later edge, when it commits, and so see it
  assign step_we    = in_accept && (in_data.kind == ies_pkg::KIND_STEP_WR) &&
                      (9'(in_data.step_index) < 9'(STEPS));
  assign step_waddr = SAW'(in_prog) * SAW'(STEPS) + SAW'(in_data.step_index);

  ies_ram #(.WIDTH(7), .DEPTH(PROGRAMS * STEPS)) u_env_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr),
    .wdata ({in_data.volume, in_data.distortion}),
    .re    (commit),
    .raddr (slot(active_nxt, env_nxt)),
    .rdata (env_q)
  );

  ies_ram #(.WIDTH(34), .DEPTH(PROGRAMS * STEPS)) u_pitch_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (step_waddr),
    .wdata ({in_data.pitch_kind, in_data.pitch_amount}),
    .re    (commit),
    .raddr (slot(active_nxt, pit_nxt)),
    .rdata (pitch_q)
  );

  assign env_inc = env_r + IXW'(1);
  assign pit_inc = pit_r + IXW'(1);

  // Voice update for the item leaving stage one
  always_comb begin
    active_nxt = active_r;
    note_nxt   = note_r;
    velo_nxt   = velo_r;
    rel_nxt    = rel_r;
    silent_nxt = silent_r;
    env_nxt    = env_r;
    pit_nxt    = pit_r;
    psc_nxt    = psc_r;
    h_nxt      = h_r;
    hdr_mod    = hdr_cur;
    hdr_we     = 1'b0;
    if (commit) begin
      unique case (s1_item_r.kind)
        ies_pkg::KIND_TICK: begin
          if (!silent_r) begin
            // Pitch index moves only when its speed counter runs out
            if (psc_r == 8'd0) begin
              psc_nxt = h_r.pitch_speed;
              pit_nxt = (pit_inc > IXW'(h_r.pitch_end)) ? IXW'(h_r.pitch_loop) : pit_inc;
            end else begin
              psc_nxt = psc_r - 8'd1;
            end
            env_nxt = env_inc;
            if (!rel_r) begin
              if (env_inc > IXW'(h_r.loop_end)) env_nxt = IXW'(h_r.loop_start);
            end else if (env_inc > IXW'(h_r.rel_stop)) begin
              silent_nxt = 1'b1;
            end
          end
        end
        ies_pkg::KIND_START: begin
          note_nxt   = s1_item_r.note;
          velo_nxt   = s1_item_r.velocity;
          active_nxt = s1_prog_r;
          rel_nxt    = 1'b0;
          silent_nxt = 1'b0;
          env_nxt    = '0;
          pit_nxt    = '0;
          psc_nxt    = hdr_cur.pitch_speed;
          h_nxt      = hdr_cur;
        end
        ies_pkg::KIND_RELEASE: begin
          if (!silent_r && !rel_r) begin
            rel_nxt = 1'b1;
            env_nxt = IXW'(h_r.loop_end);
            if (h_r.loop_end > h_r.rel_stop) silent_nxt = 1'b1;
          end
        end
        ies_pkg::KIND_HDR_WR: begin
          unique case (s1_item_r.header_word)
            ies_pkg::HDR_CHANNELS:    hdr_mod.channels    = s1_item_r.pitch_amount[1:0];
            ies_pkg::HDR_CLOCK:       hdr_mod.clock       = s1_item_r.pitch_amount[1:0];
            ies_pkg::HDR_LOOP_START:  hdr_mod.loop_start  = sat_index(s1_item_r.pitch_amount);
            ies_pkg::HDR_LOOP_END:    hdr_mod.loop_end    = sat_index(s1_item_r.pitch_amount);
            ies_pkg::HDR_REL_STOP:    hdr_mod.rel_stop    = sat_index(s1_item_r.pitch_amount);
            ies_pkg::HDR_PITCH_END:   hdr_mod.pitch_end   = sat_index(s1_item_r.pitch_amount);
            ies_pkg::HDR_PITCH_LOOP:  hdr_mod.pitch_loop  = sat_index(s1_item_r.pitch_amount);
            default:                  hdr_mod.pitch_speed = s1_item_r.pitch_amount[7:0];
          endcase
          hdr_we = 1'b1;
          // Keep the live copy in step with the active program's entry
          if (s1_prog_r == active_r) h_nxt = hdr_mod;
        end
        default: ;
      endcase
    end
  end

  // Result formed from the stage-two snapshot and the step reads
  always_comb begin
    out_nxt                     = '0;
    out_nxt.current_note        = s2_note_r;
    out_nxt.is_silent           = s2_silent_r;
    if (!s2_silent_r) begin
      out_nxt.channel_mode        = s2_chan_r;
      out_nxt.clock_mode          = s2_clk_r;
      out_nxt.current_pitch_kind  = pitch_q[33:32];
      out_nxt.current_pitch_value = pitch_q[31:0];
      if (s2_chan_r == ies_pkg::ONE_CHANNEL) begin
        out_nxt.audc = ies_pkg::dist_bits(env_q[2:0]) |
                       {4'd0, ies_pkg::scale_volume(s2_velo_r, env_q[6:3])};
      end
    end
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      note_r      <= '0;
      velo_r      <= 7'd127;
      rel_r       <= 1'b0;
      silent_r    <= 1'b1;
      env_r       <= '0;
      pit_r       <= '0;
      psc_r       <= '0;
    end else begin
      if (adv) begin
        s1_valid_r  <= in_valid;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
      active_r <= active_nxt;
      note_r   <= note_nxt;
      velo_r   <= velo_nxt;
      rel_r    <= rel_nxt;
      silent_r <= silent_nxt;
      env_r    <= env_nxt;
      pit_r    <= pit_nxt;
      psc_r    <= psc_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (in_accept) begin
      s1_item_r <= in_data;
      s1_prog_r <= in_prog;
      hit_r     <= hdr_we && (s1_prog_r == in_prog);
      hdr_fwd_r <= hdr_mod;
    end
    if (adv) begin
      s2_silent_r <= silent_nxt;
      s2_chan_r   <= h_nxt.channels;
      s2_clk_r    <= h_nxt.clock;
      s2_note_r   <= note_nxt;
      s2_velo_r   <= velo_nxt;
      out_data_r  <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An item in stage two must reach the output register on advance
  `IES_ASSERT_NEXT(a_result_follows, clk, rst_n, adv && s2_valid_r, out_valid_r, "result dropped between stage two and output")
  // A sounding voice never points past the last step
  `IES_ASSERT_IMPLY(a_env_in_range, clk, rst_n, !silent_r, env_r < IXW'(STEPS), "envelope index beyond table while sounding")
  // The pitch index stays inside the table while the voice sounds
  `IES_ASSERT_IMPLY(a_pitch_in_range, clk, rst_n, !silent_r, pit_r < IXW'(STEPS), "pitch index beyond table while sounding")

endmodule
